// ----- rtl/bba_pkg.sv -----
package bba_pkg;

    localparam int PAGE_ORDER = 12;
    localparam int POOL_ORDER = 20;
    localparam int TOP_ORDER  = POOL_ORDER - PAGE_ORDER;
    localparam int NPAGES     = 1 << TOP_ORDER;
    localparam int PAGE_W     = TOP_ORDER;
    localparam int ORD_W      = 4;
    localparam int OFLD_W     = 5;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_ALLOC = 2'd0,
        ST_FAIL  = 2'd1,
        ST_FREED = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_SPLIT,
        S_FCHK,
        S_MERGE,
        S_FIN
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [31:0] request_size;
        logic [7:0]  block_page;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [7:0] start_page;
        logic [3:0] block_order;
    } t_result;

    typedef struct packed {
        logic              free;
        logic [OFLD_W-1:0] ord_p1;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] addr;
        t_entry            data;
    } t_wr_req;

    function automatic t_entry make_entry(logic [ORD_W-1:0] ord, logic is_free);
        t_entry e;
        e.free   = is_free;
        e.ord_p1 = OFLD_W'(ord) + OFLD_W'(1);
        return e;
    endfunction

    function automatic logic [PAGE_W-1:0] bit_of(logic [ORD_W-1:0] ord);
        return PAGE_W'(1) << ord;
    endfunction

endpackage

// ----- rtl/buddy_block_allocator.sv -----
// Buddy allocator over a pool of 256 pages with one table entry per page.
// A transaction is taken when start is high and busy is low; i_cmd carries
// the action (allocate or free), the request size in bytes and the page of
// the block to free. Each transaction gives exactly one result on o_result,
// shown for one cycle with o_result_valid high; the receiver cannot stall it.
// An allocation walks the block table from page 0, one block per cycle, and
// stops at the first free block of exactly the needed order or at the end of
// the pool; failing an exact fit it takes the first smallest larger free
// block. It then writes one split-off buddy per cycle and the taken block.
// A request larger than the pool answers in the cycle after it is taken.
// A free reads the head entry, then takes one merge step at a time and ends
// with a final write; a bad free or a free of the whole pool answers after
// the head read alone. The table's single read port paces every step, since
// each step waits on its registered read. Transactions are handled one at
// a time; the next can be taken in the cycle that shows the previous result.
// After reset the table is cleared, one entry per cycle, while busy stays
// high; the pool then holds one free block covering all pages.
module buddy_block_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bba_pkg::t_cmd     i_cmd,
    output logic              o_result_valid,
    output bba_pkg::t_result  o_result
);
    import bba_pkg::*;

    t_state              r_state, n_state;
    logic [PAGE_W-1:0]   r_clr, n_clr;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [ORD_W-1:0]    r_ord, n_ord;
    logic [ORD_W-1:0]    r_need, n_need;
    logic                r_found, n_found;
    logic [PAGE_W-1:0]   r_best_page, n_best_page;
    logic [ORD_W-1:0]    r_best_ord, n_best_ord;
    t_result             r_res, n_res;
    logic                r_res_valid, n_res_valid;

    t_wr_req             wr;
    logic                rd_en;
    logic [PAGE_W-1:0]   rd_addr;
    t_entry              rd_data;

    logic                accept;
    logic [ORD_W-1:0]    size_ord;
    logic                too_big;
    logic                head_ok;
    logic [ORD_W-1:0]    cur_ord;
    logic [PAGE_W:0]     walk_next;
    logic                cand;
    logic                walk_last;
    logic                entry_bad;
    logic                buddy_avail;
    logic [ORD_W-1:0]    merge_ord;
    logic [PAGE_W-1:0]   merge_page;

    bba_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy           = (r_state != S_IDLE);
    assign accept         = start && !busy;
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    always_comb begin
        size_ord = '0;
        for (int o = 0; o <= TOP_ORDER; o++) begin
            size_ord = size_ord + ORD_W'(33'(i_cmd.request_size) > (33'(1) << (PAGE_ORDER + o)));
        end
    end
    assign too_big = (size_ord > ORD_W'(TOP_ORDER));

    assign head_ok    = (rd_data.ord_p1 != '0) && (rd_data.ord_p1 <= OFLD_W'(TOP_ORDER + 1));
    assign cur_ord    = ORD_W'(rd_data.ord_p1 - OFLD_W'(1));
    assign walk_next  = {1'b0, r_page} + (head_ok ? ((PAGE_W + 1)'(1) << cur_ord)
                                                  : (PAGE_W + 1)'(1));
    assign cand       = head_ok && rd_data.free && (cur_ord >= r_need)
                        && (!r_found || (cur_ord < r_best_ord));
    assign walk_last  = (cand && (cur_ord == r_need)) || walk_next[PAGE_W];
    assign entry_bad  = !head_ok || rd_data.free;
    assign buddy_avail = (rd_data == make_entry(r_ord, 1'b1));
    assign merge_ord  = r_ord + ORD_W'(1);
    assign merge_page = r_page & ~bit_of(r_ord);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == PAGE_W'(NPAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.action == ACT_FREE) begin
                        n_state = S_FCHK;
                    end else if (!too_big) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = (r_found || cand) ? S_SPLIT : S_IDLE;
                end
            end
            S_SPLIT: begin
                if (r_ord == r_need) begin
                    n_state = S_IDLE;
                end
            end
            S_FCHK: begin
                if (entry_bad || (cur_ord == ORD_W'(TOP_ORDER))) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (!buddy_avail) begin
                    n_state = S_IDLE;
                end else if (merge_ord == ORD_W'(TOP_ORDER)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_clr       = r_clr;
        n_page      = r_page;
        n_ord       = r_ord;
        n_need      = r_need;
        n_found     = r_found;
        n_best_page = r_best_page;
        n_best_ord  = r_best_ord;
        n_res       = r_res;
        n_res_valid = 1'b0;
        wr          = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr.en   = 1'b1;
                wr.addr = r_clr;
                wr.data = (r_clr == '0) ? make_entry(ORD_W'(TOP_ORDER), 1'b1) : '0;
                n_clr   = r_clr + PAGE_W'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.action == ACT_FREE) begin
                        rd_en   = 1'b1;
                        rd_addr = i_cmd.block_page[PAGE_W-1:0];
                        n_page  = i_cmd.block_page[PAGE_W-1:0];
                    end else if (too_big) begin
                        n_res_valid = 1'b1;
                        n_res       = '{status: ST_FAIL, start_page: '0, block_order: '0};
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_page  = '0;
                        n_found = 1'b0;
                        n_need  = size_ord;
                    end
                end
            end
            S_WALK: begin
                if (cand) begin
                    n_found     = 1'b1;
                    n_best_page = r_page;
                    n_best_ord  = cur_ord;
                end
                if (walk_last) begin
                    if (cand) begin
                        n_page = r_page;
                        n_ord  = cur_ord;
                    end else if (r_found) begin
                        n_page = r_best_page;
                        n_ord  = r_best_ord;
                    end else begin
                        n_res_valid = 1'b1;
                        n_res       = '{status: ST_FAIL, start_page: '0, block_order: '0};
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = walk_next[PAGE_W-1:0];
                    n_page  = walk_next[PAGE_W-1:0];
                end
            end
            S_SPLIT: begin
                wr.en = 1'b1;
                if (r_ord != r_need) begin
                    wr.addr = r_page ^ bit_of(r_ord - ORD_W'(1));
                    wr.data = make_entry(r_ord - ORD_W'(1), 1'b1);
                    n_ord   = r_ord - ORD_W'(1);
                end else begin
                    wr.addr     = r_page;
                    wr.data     = make_entry(r_need, 1'b0);
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_ALLOC, start_page: 8'(r_page),
                                    block_order: r_need};
                end
            end
            S_FCHK: begin
                if (entry_bad) begin
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_BAD, start_page: '0, block_order: '0};
                end else if (cur_ord == ORD_W'(TOP_ORDER)) begin
                    wr.en       = 1'b1;
                    wr.addr     = r_page;
                    wr.data     = make_entry(cur_ord, 1'b1);
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_FREED, start_page: 8'(r_page),
                                    block_order: cur_ord};
                end else begin
                    wr.en   = 1'b1;
                    wr.addr = r_page;
                    wr.data = '0;
                    rd_en   = 1'b1;
                    rd_addr = r_page ^ bit_of(cur_ord);
                    n_ord   = cur_ord;
                end
            end
            S_MERGE: begin
                wr.en = 1'b1;
                if (buddy_avail) begin
                    wr.addr = r_page ^ bit_of(r_ord);
                    wr.data = '0;
                    n_page  = merge_page;
                    n_ord   = merge_ord;
                    if (merge_ord != ORD_W'(TOP_ORDER)) begin
                        rd_en   = 1'b1;
                        rd_addr = merge_page ^ bit_of(merge_ord);
                    end
                end else begin
                    wr.addr     = r_page;
                    wr.data     = make_entry(r_ord, 1'b1);
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_FREED, start_page: 8'(r_page),
                                    block_order: r_ord};
                end
            end
            S_FIN: begin
                wr.en       = 1'b1;
                wr.addr     = r_page;
                wr.data     = make_entry(r_ord, 1'b1);
                n_res_valid = 1'b1;
                n_res       = '{status: ST_FREED, start_page: 8'(r_page),
                                block_order: r_ord};
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_found     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_found     <= n_found;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page      <= n_page;
        r_ord       <= n_ord;
        r_need      <= n_need;
        r_best_page <= n_best_page;
        r_best_ord  <= n_best_ord;
        r_res       <= n_res;
    end

`ifndef NO_ASSERTIONS
    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en && rd_en) |-> (wr.addr != rd_addr))
        else $error("table read and write hit the same entry in one cycle");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted transaction neither started nor answered");

    a_merge_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_ord < ORD_W'(TOP_ORDER)))
        else $error("merge step at the top order");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while a transaction is in progress");

    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_ord >= r_need))
        else $error("split level fell below the requested order");
`endif

endmodule

// ----- rtl/bba_table.sv -----
module bba_table (
    input  logic                          i_clk,
    input  bba_pkg::t_wr_req              i_wr,
    input  logic                          i_rd_en,
    input  logic [bba_pkg::PAGE_W-1:0]    i_rd_addr,
    output bba_pkg::t_entry               o_rd_data
);
    import bba_pkg::*;

    t_entry mem [NPAGES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// ----- tb/buddy_block_allocator_tb.sv -----
`timescale 1ns / 100ps

module buddy_block_allocator_tb;
    import bba_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int PHASE_ITEMS    = 400;
    localparam int IDLE_PLAN [4]  = '{0, 50, 0, 30};

    typedef struct packed {
        t_cmd    cmd;
        logic    known;
        t_result want;
    } t_stim_row;

    localparam t_result NONE = '{ST_FAIL, 8'd0, 4'd0};

    localparam t_stim_row DIRECTED [23] = '{
        '{'{ACT_ALLOC, 32'd0,          8'd0},   1'b1, '{ST_ALLOC, 8'd0, 4'd0}},
        '{'{ACT_FREE,  32'd0,          8'd0},   1'b1, '{ST_FREED, 8'd0, 4'd8}},
        '{'{ACT_ALLOC, 32'h0010_0000,  8'hFF},  1'b1, '{ST_ALLOC, 8'd0, 4'd8}},
        '{'{ACT_ALLOC, 32'd1,          8'd0},   1'b1, '{ST_FAIL,  8'd0, 4'd0}},
        '{'{ACT_FREE,  32'hFFFF_FFFF,  8'd0},   1'b1, '{ST_FREED, 8'd0, 4'd8}},
        '{'{ACT_FREE,  32'd0,          8'd0},   1'b1, '{ST_BAD,   8'd0, 4'd0}},
        '{'{ACT_ALLOC, 32'h0010_0001,  8'd0},   1'b1, '{ST_FAIL,  8'd0, 4'd0}},
        '{'{ACT_ALLOC, 32'hFFFF_FFFF,  8'd0},   1'b1, '{ST_FAIL,  8'd0, 4'd0}},
        '{'{ACT_ALLOC, 32'h0000_1000,  8'd0},   1'b1, '{ST_ALLOC, 8'd0, 4'd0}},
        '{'{ACT_ALLOC, 32'h0000_1001,  8'd0},   1'b0, NONE},
        '{'{ACT_ALLOC, 32'd1,          8'd0},   1'b0, NONE},
        '{'{ACT_FREE,  32'd0,          8'd5},   1'b1, '{ST_BAD,   8'd0, 4'd0}},
        '{'{ACT_FREE,  32'd0,          8'd4},   1'b1, '{ST_BAD,   8'd0, 4'd0}},
        '{'{ACT_FREE,  32'd0,          8'd2},   1'b0, NONE},
        '{'{ACT_FREE,  32'd0,          8'd2},   1'b1, '{ST_BAD,   8'd0, 4'd0}},
        '{'{ACT_ALLOC, 32'h0008_0000,  8'd0},   1'b0, NONE},
        '{'{ACT_FREE,  32'd0,          8'd255}, 1'b1, '{ST_BAD,   8'd0, 4'd0}},
        '{'{ACT_FREE,  32'd0,          8'd1},   1'b0, NONE},
        '{'{ACT_FREE,  32'd0,          8'd0},   1'b0, NONE},
        '{'{ACT_FREE,  32'd0,          8'd128}, 1'b0, NONE},
        '{'{ACT_FREE,  32'd0,          8'd0},   1'b1, '{ST_BAD,   8'd0, 4'd0}},
        '{'{ACT_ALLOC, 32'h000F_FFFF,  8'd0},   1'b1, '{ST_ALLOC, 8'd0, 4'd8}},
        '{'{ACT_FREE,  32'd0,          8'd0},   1'b1, '{ST_FREED, 8'd0, 4'd8}}
    };

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    t_entry     page_map [NPAGES];
    t_result    expected_results [$];
    logic [7:0] live_blocks [$];
    int         idle_pct     = 0;
    int         fail_count   = 0;
    int         stall_cycles = 0;
    int         n_sent       = 0;
    int         n_alloc      = 0;
    int         n_refused    = 0;
    int         n_freed      = 0;
    int         n_bad        = 0;
    int         n_top_merge  = 0;

    buddy_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_entry head_entry(int order, bit is_free);
        t_entry e;
        e.free   = is_free;
        e.ord_p1 = OFLD_W'(order + 1);
        return e;
    endfunction

    function automatic t_result pool_outcome(t_cmd c);
        t_result r;
        t_entry  e;
        int      need;
        int      k;
        int      p;
        int      lvl;
        int      o;
        int      buddy;
        bit      found;
        r.status      = ST_FAIL;
        r.start_page  = '0;
        r.block_order = '0;
        if (c.action == ACT_ALLOC) begin
            need = -1;
            for (int j = TOP_ORDER; j >= 0; j--) begin
                if ((64'd1 << (PAGE_ORDER + j)) >= 64'(c.request_size)) need = j;
            end
            found = 1'b0;
            p     = 0;
            k     = need;
            if (need >= 0) begin
                while (!found && k <= TOP_ORDER) begin
                    for (p = 0; p < NPAGES; p += (1 << k)) begin
                        if (page_map[p] == head_entry(k, 1'b1)) begin
                            found = 1'b1;
                            break;
                        end
                    end
                    if (!found) k++;
                end
            end
            if (found) begin
                lvl = k;
                while (lvl > need) begin
                    lvl--;
                    page_map[p ^ (1 << lvl)] = head_entry(lvl, 1'b1);
                end
                page_map[p]   = head_entry(need, 1'b0);
                r.status      = ST_ALLOC;
                r.start_page  = 8'(p);
                r.block_order = 4'(need);
            end
        end else begin
            p = int'(c.block_page) % NPAGES;
            e = page_map[p];
            if (e.ord_p1 == '0 || e.free || int'(e.ord_p1) - 1 > TOP_ORDER) begin
                r.status = ST_BAD;
            end else begin
                o           = int'(e.ord_p1) - 1;
                page_map[p] = '0;
                while (o < TOP_ORDER) begin
                    buddy = p ^ (1 << o);
                    if (page_map[buddy] != head_entry(o, 1'b1)) break;
                    page_map[buddy] = '0;
                    if (buddy < p) p = buddy;
                    o++;
                end
                page_map[p]   = head_entry(o, 1'b1);
                r.status      = ST_FREED;
                r.start_page  = 8'(p);
                r.block_order = 4'(o);
            end
        end
        return r;
    endfunction

    function automatic void log_failure(string what);
        fail_count++;
        if (fail_count <= 10) $display("ERROR at %0t ns: %s", $time, what);
    endfunction

    task automatic issue_cmd(input t_cmd c, input bit known, input t_result want);
        t_result r;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_sent++;
        r = pool_outcome(c);
        expected_results.push_back(known ? want : r);
        if (r.status == ST_ALLOC) live_blocks.push_back(r.start_page);
        if (r.status == ST_FREED) begin
            for (int j = 0; j < live_blocks.size(); j++) begin
                if (live_blocks[j] == c.block_page) begin
                    live_blocks.delete(j);
                    break;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                log_failure($sformatf("unexpected result status=%0d page=%0d order=%0d",
                                      o_result.status, o_result.start_page,
                                      o_result.block_order));
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status ||
                    o_result.start_page !== want.start_page ||
                    o_result.block_order !== want.block_order) begin
                    log_failure($sformatf(
                        "expected status=%0d page=%0d order=%0d, got status=%0d page=%0d order=%0d",
                        want.status, want.start_page, want.block_order,
                        o_result.status, o_result.start_page, o_result.block_order));
                end
                case (want.status)
                    ST_ALLOC: n_alloc++;
                    ST_FAIL:  n_refused++;
                    ST_FREED: begin
                        n_freed++;
                        if (want.block_order == 4'(TOP_ORDER)) n_top_merge++;
                    end
                    default:  n_bad++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_result_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        int   pick;
        int   k;
        foreach (page_map[i]) page_map[i] = '0;
        page_map[0] = head_entry(TOP_ORDER, 1'b1);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) issue_cmd(DIRECTED[i].cmd, DIRECTED[i].known, DIRECTED[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = IDLE_PLAN[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                c    = '0;
                if (pick < 45 && live_blocks.size() > 0) begin
                    c.action       = ACT_FREE;
                    c.block_page   = live_blocks[$urandom_range(live_blocks.size() - 1)];
                end else if (pick < 55) begin
                    c.action       = ACT_FREE;
                    c.block_page   = 8'($urandom);
                    c.request_size = $urandom;
                end else begin
                    c.action     = ACT_ALLOC;
                    c.block_page = 8'($urandom);
                    if (pick > 95) begin
                        c.request_size = $urandom;
                    end else begin
                        k = ($urandom_range(3) == 0) ? $urandom_range(TOP_ORDER)
                                                     : $urandom_range(2);
                        c.request_size = (k == 0) ? $urandom_range(1 << PAGE_ORDER)
                            : $urandom_range(1 << (PAGE_ORDER + k),
                                             (1 << (PAGE_ORDER + k - 1)) + 1);
                    end
                end
                issue_cmd(c, 1'b0, NONE);
            end
        end
        start <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions over four sender idle phases (0/50/0/30 percent).",
                 n_sent);
        $display("Results: %0d allocated, %0d refused, %0d freed (%0d to full pool), %0d bad.",
                 n_alloc, n_refused, n_freed, n_top_merge, n_bad);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatch count: %0d", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
